// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rbf field evaluator
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbf check failed");

// condition never holds
`define CHK_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rbf check failed");

`endif

// ===== hdl/rbf_pkg.sv =====
// shared constants, types and helpers of the gaussian rbf field evaluator
// no dependencies
package rbf_pkg;

	localparam int MAX_LANDMARKS   = 64;
	localparam int EXP_TABLE_DEPTH = 256;

	localparam int LM_AW     = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
	localparam int CNT_W     = $clog2(MAX_LANDMARKS + 1);
	localparam int ACC_W     = 33 + $clog2(MAX_LANDMARKS + 1);
	localparam int EXP_IX_W  = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int TP_W      = 36 + EXP_IX_W;
	localparam int DIV_STEPS = 64;

	localparam logic [63:0] Q62_ONE = 64'd1 << 62;
	localparam logic [63:0] STEP_Q  = Q62_ONE / EXP_TABLE_DEPTH;
	localparam logic [63:0] STEP_R  = Q62_ONE % EXP_TABLE_DEPTH;
	localparam logic [63:0] STEP_H  = STEP_Q * 16 + (STEP_R * 16) / EXP_TABLE_DEPTH;

	typedef logic [31:0] exp_tab_t [0:EXP_TABLE_DEPTH];

	// one landmark entry as stored
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [31:0]        inv;
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] wz;
	} lmk_t;

	// inverse-radius unit result
	typedef struct packed {
		logic        done;
		logic [31:0] inv;
	} inv_res_t;

	// q0.62 product, rounded half up
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b} + (128'd1 << 61);
		return p[125:62];
	endfunction

	// floor(x / d) for a small nonzero d, shift and subtract
	function automatic logic [63:0] udiv_small(input logic [63:0] x, input logic [5:0] d);
		logic [63:0] q;
		logic [6:0]  r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[5:0], x[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-16k/depth) in q1.30, built at elaboration
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t     tab;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [63:0]  e;
		logic [127:0] r;
		term = Q62_ONE;
		sum  = Q62_ONE;
		e    = Q62_ONE;
		for (int n = 1; n <= 40; n++) begin
			term = udiv_small(mul_q62(term, STEP_H), 6'(n));
			if (n[0]) sum = sum - term;
			else sum = sum + term;
		end
		for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
			r = {64'd0, e} + 128'(64'd1 << 31);
			tab[k] = r[63:32];
			e = mul_q62(e, sum);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	// |a - b| of two signed words
	function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return d[32] ? 32'(-d) : d[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] w);
		return w[31] ? 32'(-33'(w)) : 32'(w);
	endfunction

	// weight*g rounded to q16.16, ties away from zero
	function automatic logic signed [ACC_W-1:0] scale_term(input logic [63:0] prod,
			input logic neg);
		logic [62:0] r;
		logic signed [ACC_W-1:0] m;
		r = prod[62:0] + 63'(64'd1 << 29);
		m = ACC_W'(r[62:30]);
		return neg ? -m : m;
	endfunction

endpackage

// ===== hdl/rbf_mul.sv =====
// shared 32x32 unsigned multiplier with registered product
// depends on nothing
module rbf_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= {32'd0, a} * {32'd0, b};
	end
endmodule

// ===== hdl/rbf_inv.sv =====
// inverse squared radius: round(2^56 / r2), one quotient bit per cycle
// depends on rbf_pkg
module rbf_inv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         r2,
	output rbf_pkg::inv_res_t   res
);
	import rbf_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] inv_q;
	logic [64:0] trial;
	logic        ge;
	logic [63:0] quo_nxt;

	always_comb begin
		trial   = {rem_q, num_q[63]};
		ge      = trial >= {1'b0, den_q};
		quo_nxt = {quo_q[62:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (r2 == '0) done_q <= 1'b1;
				else busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= (64'd1 << 56) + (r2 >> 1);
			den_q <= r2;
			rem_q <= '0;
			quo_q <= '0;
			inv_q <= '1;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			num_q <= {num_q[62:0], 1'b0};
			quo_q <= quo_nxt;
			inv_q <= (quo_nxt[63:32] != '0) ? '1 : quo_nxt[31:0];
		end
	end

	assign res.done = done_q;
	assign res.inv  = inv_q;
endmodule

// ===== hdl/rbf_lmk_mem.sv =====
// landmark table, one write and one registered read per cycle
// depends on rbf_pkg
module rbf_lmk_mem (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [rbf_pkg::LM_AW-1:0] wr_addr,
	input  rbf_pkg::lmk_t            wr_data,
	input  logic [rbf_pkg::LM_AW-1:0] rd_addr,
	output rbf_pkg::lmk_t            rd_q
);
	import rbf_pkg::*;

	lmk_t mem [0:MAX_LANDMARKS-1];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end
endmodule

// ===== hdl/gaussian_rbf_field_eval_top.sv =====
// gaussian rbf displacement field evaluator, top level with sequencer
// depends on rbf_pkg, rbf_mul, rbf_inv, rbf_lmk_mem, assert_macros.svh
//
// channel | direction | handshake          | beat
// in      | input     | in_valid/in_stall   | load entry or evaluate point
// out     | output    | out_valid/out_stall | saturated displacement
// cfg     | input     | cfg_we              | landmark_count
//
// a load beat squares the radius in the shared multiplier, then the bit-serial
// divider forms the inverse squared radius.
// in an evaluate beat every landmark used goes through the one shared 32x32
// multiplier nine times (three squares, two for t, one for the table
// interpolation, three weights) besides read and bookkeeping states.
// in_stall is high whenever a beat is in work; the result waits in an output
// register, so a new beat is taken while out_stall holds the last result.
// reset clears the sequencer, the output valid and landmark_count; the table
// holds garbage until loaded.
`include "assert_macros.svh"

module gaussian_rbf_field_eval_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [5:0]         entry_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [31:0]        kernel_radius,
	input  logic signed [31:0] weight_x,
	input  logic signed [31:0] weight_y,
	input  logic signed [31:0] weight_z,
	input  logic signed [31:0] base_dx,
	input  logic signed [31:0] base_dy,
	input  logic signed [31:0] base_dz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] disp_x,
	output logic signed [31:0] disp_y,
	output logic signed [31:0] disp_z,
	output logic               saturated
);
	import rbf_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_LSQ, S_LDST, S_LDIV,
		S_CHK, S_RD, S_DX, S_DY, S_DZ, S_D2, S_PHI, S_LO, S_T, S_INT, S_G,
		S_WX, S_WY, S_WZ, S_AZ, S_OUT
	} state_t;

	state_t state_q;
	logic [6:0]       landmark_count_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] n_q;
	logic             out_valid_q;
	logic             in_acc;

	// captured beat
	logic [5:0]         index_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [31:0]        radius_q;
	logic signed [31:0] wx_q, wy_q, wz_q;

	// per landmark datapath
	logic [63:0]             d2_q;
	logic [63:0]             phi_q;
	logic [31:0]             a_q, b_q, frac_q, g_q;
	logic                    far_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic signed [31:0]      disp_x_q, disp_y_q, disp_z_q;
	logic                    sat_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	lmk_t        rd_q;
	lmk_t        wr_data;
	logic        wr_en;
	inv_res_t    inv_res;

	logic [64:0]         d2_sum;
	logic [63:0]         d2_sat;
	logic [40:0]         t_val;
	logic                t_far;
	logic [TP_W-1:0]     tp;
	logic [EXP_IX_W-1:0] idx;
	logic                dec;
	logic [31:0]         diff_ab;
	logic [31:0]         g_nxt;
	logic                clip_x, clip_y, clip_z;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign disp_x    = disp_x_q;
	assign disp_y    = disp_y_q;
	assign disp_z    = disp_z_q;
	assign saturated = sat_q;

	rbf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));

	rbf_inv u_inv (
		.clk(clk), .arst_n(arst_n),
		.start(state_q == S_LDST), .r2(prod_q), .res(inv_res)
	);

	// slots past the table are dropped
	assign wr_en = inv_res.done && (32'(index_q) < 32'(MAX_LANDMARKS));
	always_comb begin
		wr_data.cx  = px_q;
		wr_data.cy  = py_q;
		wr_data.cz  = pz_q;
		wr_data.inv = inv_res.inv;
		wr_data.wx  = wx_q;
		wr_data.wy  = wy_q;
		wr_data.wz  = wz_q;
	end

	rbf_lmk_mem u_mem (
		.clk(clk), .wr_en(wr_en), .wr_addr(LM_AW'(index_q)), .wr_data(wr_data),
		.rd_addr(i_q[LM_AW-1:0]), .rd_q(rd_q)
	);

	// operand select for the shared multiplier
	always_comb begin
		dec     = a_q >= b_q;
		diff_ab = dec ? (a_q - b_q) : (b_q - a_q);
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			S_LSQ: begin
				mul_a = radius_q;
				mul_b = radius_q;
			end
			S_DX: begin
				mul_a = abs_diff(rd_q.cx, px_q);
				mul_b = mul_a;
			end
			S_DY: begin
				mul_a = abs_diff(rd_q.cy, py_q);
				mul_b = mul_a;
			end
			S_DZ: begin
				mul_a = abs_diff(rd_q.cz, pz_q);
				mul_b = mul_a;
			end
			S_PHI: begin
				mul_a = d2_q[63:32];
				mul_b = rd_q.inv;
			end
			S_LO: begin
				mul_a = d2_q[31:0];
				mul_b = rd_q.inv;
			end
			S_INT: begin
				mul_a = diff_ab;
				mul_b = frac_q;
			end
			S_WX: begin
				mul_a = mag32(rd_q.wx);
				mul_b = g_q;
			end
			S_WY: begin
				mul_a = mag32(rd_q.wy);
				mul_b = g_q;
			end
			S_WZ: begin
				mul_a = mag32(rd_q.wz);
				mul_b = g_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// squared distance accumulates with saturation at 2^64-1
	always_comb begin
		d2_sum = {1'b0, d2_q} + {1'b0, prod_q};
		d2_sat = d2_sum[64] ? '1 : d2_sum[63:0];
	end

	// t = d2*inv/2^24 in q.32, table position and fraction
	always_comb begin
		t_val = 41'({phi_q[27:0], 8'd0}) + 41'(prod_q[63:24]);
		t_far = (phi_q[63:28] != '0) || (t_val[40:36] != '0);
		tp    = TP_W'(t_val[35:0]) * TP_W'(EXP_TABLE_DEPTH);
		idx   = tp[TP_W-1:36];
	end

	always_comb begin
		if (far_q) g_nxt = '0;
		else if (dec) g_nxt = a_q - prod_q[63:32];
		else g_nxt = a_q + prod_q[63:32];
	end

	always_comb begin
		clip_x = (acc_x_q[ACC_W-1:31] != '0) && (acc_x_q[ACC_W-1:31] != '1);
		clip_y = (acc_y_q[ACC_W-1:31] != '0) && (acc_y_q[ACC_W-1:31] != '1);
		clip_z = (acc_z_q[ACC_W-1:31] != '0) && (acc_z_q[ACC_W-1:31] != '1);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			landmark_count_q <= '0;
			i_q              <= '0;
			n_q              <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) landmark_count_q <= cfg_data;
			// a new result replaces the taken one, otherwise a taken result retires
			if (state_q == S_OUT && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						i_q <= '0;
						n_q <= (32'(landmark_count_q) > 32'(MAX_LANDMARKS)) ?
							CNT_W'(MAX_LANDMARKS) : CNT_W'(landmark_count_q);
						state_q <= kind ? S_CHK : S_LSQ;
					end
				end
				S_LSQ:  state_q <= S_LDST;
				S_LDST: state_q <= S_LDIV;
				S_LDIV: if (inv_res.done) state_q <= S_IDLE;
				S_CHK:  state_q <= (i_q == n_q) ? S_OUT : S_RD;
				S_RD:   state_q <= S_DX;
				S_DX:   state_q <= S_DY;
				S_DY:   state_q <= S_DZ;
				S_DZ:   state_q <= S_D2;
				S_D2:   state_q <= S_PHI;
				S_PHI:  state_q <= S_LO;
				S_LO:   state_q <= S_T;
				S_T:    state_q <= S_INT;
				S_INT:  state_q <= S_G;
				S_G:    state_q <= S_WX;
				S_WX:   state_q <= S_WY;
				S_WY:   state_q <= S_WZ;
				S_WZ:   state_q <= S_AZ;
				S_AZ: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_CHK;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			index_q  <= entry_index;
			px_q     <= pos_x;
			py_q     <= pos_y;
			pz_q     <= pos_z;
			radius_q <= kernel_radius;
			wx_q     <= weight_x;
			wy_q     <= weight_y;
			wz_q     <= weight_z;
			acc_x_q  <= ACC_W'(base_dx);
			acc_y_q  <= ACC_W'(base_dy);
			acc_z_q  <= ACC_W'(base_dz);
		end
		case (state_q)
			S_DY: d2_q <= prod_q;
			S_DZ, S_D2: d2_q <= d2_sat;
			S_LO: phi_q <= prod_q;
			S_T: begin
				a_q    <= EXP_TAB[idx];
				b_q    <= EXP_TAB[idx + EXP_IX_W'(1)];
				frac_q <= tp[35:4];
				far_q  <= t_far;
			end
			S_G: g_q <= g_nxt;
			S_WY: acc_x_q <= acc_x_q + scale_term(prod_q, rd_q.wx[31]);
			S_WZ: acc_y_q <= acc_y_q + scale_term(prod_q, rd_q.wy[31]);
			S_AZ: acc_z_q <= acc_z_q + scale_term(prod_q, rd_q.wz[31]);
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					disp_x_q <= clip_x ? (acc_x_q[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
						: acc_x_q[31:0];
					disp_y_q <= clip_y ? (acc_y_q[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
						: acc_y_q[31:0];
					disp_z_q <= clip_z ? (acc_z_q[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
						: acc_z_q[31:0];
					sat_q    <= clip_x || clip_y || clip_z;
				end
			end
			default: begin
			end
		endcase
	end

	// divider results only arrive while a load waits for them
	`CHK_IMPL(a_inv_done_in_load, inv_res.done, state_q == S_LDIV)
	// the landmark walk never passes the clamped count
	`CHK_IMPL(a_walk_bound, state_q == S_CHK, i_q <= n_q)
	// a far landmark contributes nothing
	`CHK_NEVER(a_far_zero, state_q == S_WX && far_q && g_q != '0)
	// a saturation flag comes with a clipped component
	`CHK_IMPL(a_sat_clipped, out_valid && saturated,
		disp_x == 32'sh7FFF_FFFF || disp_x == -32'sh8000_0000 ||
		disp_y == 32'sh7FFF_FFFF || disp_y == -32'sh8000_0000 ||
		disp_z == 32'sh7FFF_FFFF || disp_z == -32'sh8000_0000)
endmodule

// ===== dv/tb.sv =====
// self-checking testbench for gaussian_rbf_field_eval_top: random and directed landmark loads
// and point evaluations, checked against an in-bench fixed-point predictor
// depends on the rtl top level only
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS = 64;
	localparam int EXP_DEPTH = 256;
	localparam bit KIND_LOAD = 1'b0;
	localparam bit KIND_EVAL = 1'b1;

	// one input beat, load or evaluate
	typedef struct packed {
		logic               kind;
		logic [5:0]         slot;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [31:0]        radius;
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] wz;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
	} beat_t;

	// one output beat
	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic               sat;
	} disp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        out_stall = 1'b0;
	beat_t       drv_beat = '0;
	logic signed [31:0] disp_x, disp_y, disp_z;
	logic        saturated;

	gaussian_rbf_field_eval_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(drv_beat.kind), .entry_index(drv_beat.slot),
		.pos_x(drv_beat.px), .pos_y(drv_beat.py), .pos_z(drv_beat.pz),
		.kernel_radius(drv_beat.radius),
		.weight_x(drv_beat.wx), .weight_y(drv_beat.wy), .weight_z(drv_beat.wz),
		.base_dx(drv_beat.bx), .base_dy(drv_beat.by), .base_dz(drv_beat.bz),
		.out_valid(out_valid), .out_stall(out_stall),
		.disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z),
		.saturated(saturated)
	);

	always #5 clk = ~clk;

	// predictor state: landmark table, count register, gaussian table
	logic signed [31:0] lm_cx [NUM_SLOTS];
	logic signed [31:0] lm_cy [NUM_SLOTS];
	logic signed [31:0] lm_cz [NUM_SLOTS];
	logic [31:0]        lm_inv [NUM_SLOTS];
	logic signed [31:0] lm_w [NUM_SLOTS][3];
	logic [6:0]         used_count = '0;
	logic [31:0]        gauss_tab [EXP_DEPTH+1];

	beat_t pending_beats [$];
	disp_t expected_disp [$];
	int    fail_count = 0;
	int    beats_taken = 0;
	int    loads_taken = 0;
	int    disp_checked = 0;
	int    sat_seen = 0;
	bit    no_idle = 1'b0;

	// q0.62 product rounded half up
	function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
		logic [127:0] full;
		full = {64'd0, a} * {64'd0, b};
		return 64'(((full >> 61) + 128'd1) >> 1);
	endfunction

	// exp(-16k/depth) in q1.30 by powers of a taylor-series step
	function automatic void build_gauss_tab();
		logic [63:0] one, step_arg, term, step, acc;
		one      = 64'd1 << 62;
		step_arg = (one / EXP_DEPTH) * 16 + ((one % EXP_DEPTH) * 16) / EXP_DEPTH;
		term     = one;
		step     = one;
		for (int n = 1; n <= 40 && term != 0; n++) begin
			term = q62_product(term, step_arg) / n;
			if (n % 2 == 1) step = step - term;
			else step = step + term;
		end
		acc = one;
		for (int k = 0; k <= EXP_DEPTH; k++) begin
			gauss_tab[k] = 32'((65'(acc) + 65'h8000_0000) >> 32);
			acc = q62_product(acc, step);
		end
	endfunction

	function automatic logic [63:0] diff_sq(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [32:0] d;
		logic [32:0]        m;
		d = 33'(a) - 33'(b);
		m = d[32] ? 33'(-d) : 33'(d);
		return 64'({31'd0, m} * {31'd0, m});
	endfunction

	// gaussian weight of one landmark at a point, q1.30
	function automatic logic [31:0] gauss_at(int i, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		logic [65:0] d2w;
		logic [63:0] d2, phi, t, p, inv, a, b, frac, idx;
		d2w = 66'(diff_sq(lm_cx[i], x)) + 66'(diff_sq(lm_cy[i], y)) + 66'(diff_sq(lm_cz[i], z));
		d2  = d2w[65:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : d2w[63:0];
		inv = {32'd0, lm_inv[i]};
		phi = (d2 >> 32) * inv;
		if (phi >= (64'd16 << 24)) return '0;
		t = (phi << 8) + (({32'd0, d2[31:0]} * inv) >> 24);
		if (t >= (64'd16 << 32)) return '0;
		p    = t * EXP_DEPTH / 16;
		idx  = p >> 32;
		frac = {32'd0, p[31:0]};
		if (idx >= EXP_DEPTH) return '0;
		a = {32'd0, gauss_tab[idx]};
		b = {32'd0, gauss_tab[idx+1]};
		if (a >= b) return 32'(a - (((a - b) * frac) >> 32));
		return 32'(a + (((b - a) * frac) >> 32));
	endfunction

	// weight times gaussian, q16.16, ties away from zero
	function automatic longint weighted_term(logic signed [31:0] w, logic [31:0] g);
		longint prod, mag;
		prod = longint'(w) * longint'({32'd0, g});
		mag  = prod < 0 ? -prod : prod;
		mag  = (mag + (64'sd1 <<< 29)) >>> 30;
		return prod < 0 ? -mag : mag;
	endfunction

	function automatic void store_landmark(beat_t bt);
		logic [63:0]  r2;
		logic [127:0] q;
		r2 = {32'd0, bt.radius} * {32'd0, bt.radius};
		if (r2 == 0) q = 128'hFFFF_FFFF;
		else q = ((128'd1 << 56) + 128'(r2 / 2)) / 128'(r2);
		lm_inv[bt.slot] = q > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
		lm_cx[bt.slot] = bt.px;
		lm_cy[bt.slot] = bt.py;
		lm_cz[bt.slot] = bt.pz;
		lm_w[bt.slot][0] = bt.wx;
		lm_w[bt.slot][1] = bt.wy;
		lm_w[bt.slot][2] = bt.wz;
	endfunction

	function automatic disp_t eval_displacement(beat_t bt);
		longint acc [3];
		logic [31:0] g;
		int n;
		disp_t res;
		acc[0] = bt.bx;
		acc[1] = bt.by;
		acc[2] = bt.bz;
		n = used_count > NUM_SLOTS ? NUM_SLOTS : int'(used_count);
		for (int i = 0; i < n; i++) begin
			g = gauss_at(i, bt.px, bt.py, bt.pz);
			for (int d = 0; d < 3; d++) acc[d] += weighted_term(lm_w[i][d], g);
		end
		res.sat = 1'b0;
		for (int d = 0; d < 3; d++) begin
			if (acc[d] > 64'sh7FFF_FFFF) begin
				acc[d] = 64'sh7FFF_FFFF;
				res.sat = 1'b1;
			end else if (acc[d] < -64'sh8000_0000) begin
				acc[d] = -64'sh8000_0000;
				res.sat = 1'b1;
			end
		end
		res.dx = 32'(acc[0]);
		res.dy = 32'(acc[1]);
		res.dz = 32'(acc[2]);
		return res;
	endfunction

	function automatic beat_t load_beat(int slot, int x, int y, int z, int r,
			int wx, int wy, int wz);
		beat_t bt;
		bt = '0;
		bt.kind = KIND_LOAD;
		bt.slot = 6'(slot);
		{bt.px, bt.py, bt.pz} = {x, y, z};
		bt.radius = r;
		{bt.wx, bt.wy, bt.wz} = {wx, wy, wz};
		// eval-only fields carry noise, they must not matter
		{bt.bx, bt.by, bt.bz} = {$urandom, $urandom, $urandom};
		return bt;
	endfunction

	function automatic beat_t eval_beat(int x, int y, int z, int bx, int by, int bz);
		beat_t bt;
		bt = '0;
		bt.kind = KIND_EVAL;
		bt.slot = 6'($urandom);
		{bt.px, bt.py, bt.pz} = {x, y, z};
		bt.radius = $urandom;
		{bt.wx, bt.wy, bt.wz} = {$urandom, $urandom, $urandom};
		{bt.bx, bt.by, bt.bz} = {bx, by, bz};
		return bt;
	endfunction

	// coordinate: mostly clustered at a random scale, sometimes any 32-bit value
	function automatic int rand_coord(int span);
		if ($urandom_range(0, 9) == 0) return int'($urandom);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int rand_value();
		case ($urandom_range(0, 3))
			0: return int'($urandom);
			1: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
			default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
		endcase
	endfunction

	function automatic beat_t rand_beat(bit is_load, int slot);
		int span;
		int rad;
		span = 1 << $urandom_range(8, 23);
		rad  = $urandom_range(0, 9) == 0 ? int'($urandom) : span / 2 + $urandom_range(1, 2 * span);
		if (is_load)
			return load_beat(slot, rand_coord(span), rand_coord(span), rand_coord(span), rad,
				rand_value(), rand_value(), rand_value());
		return eval_beat(rand_coord(span), rand_coord(span), rand_coord(span),
			rand_value(), rand_value(), rand_value());
	endfunction

	// input driver: one nonblocking update of in_valid per edge, payload held while stalled
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		beat_t nxt;
		bit    held;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			held = in_valid;
			if (in_valid && !in_stall) begin
				held = 1'b0;
				beats_taken++;
				if (drv_beat.kind == KIND_LOAD) begin
					loads_taken++;
					store_landmark(drv_beat);
				end else begin
					expected_disp.push_back(eval_displacement(drv_beat));
				end
			end
			if (!held) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					nxt = pending_beats.pop_front();
					drv_beat <= nxt;
					in_valid <= 1'b1;
					gap_left <= no_idle ? 0 : $urandom_range(0, 17);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: random back-pressure per beat, compare against the oldest prediction
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		disp_t want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_disp.size() == 0) begin
					$error("displacement beat with nothing expected");
					fail_count++;
				end else begin
					want = expected_disp.pop_front();
					disp_checked++;
					if (saturated) sat_seen++;
					if (disp_x !== want.dx) begin
						$error("disp_x expected %0d got %0d", want.dx, disp_x);
						fail_count++;
					end
					if (disp_y !== want.dy) begin
						$error("disp_y expected %0d got %0d", want.dy, disp_y);
						fail_count++;
					end
					if (disp_z !== want.dz) begin
						$error("disp_z expected %0d got %0d", want.dz, disp_z);
						fail_count++;
					end
					if (saturated !== want.sat) begin
						$error("saturated expected %0b got %0b", want.sat, saturated);
						fail_count++;
					end
				end
				stall_left <= no_idle ? 0 : $urandom_range(0, 17);
				out_stall  <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// block until everything queued was taken and answered, then let a load finish
	task automatic drain();
		while (pending_beats.size() != 0 || in_valid || in_stall || expected_disp.size() != 0)
			@(negedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_count(logic [6:0] val);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we   <= 1'b0;
		used_count = val;
	endtask

	// phase counts: small ones dominate, the large ones appear with fewer beats
	int phase_counts [13] = '{1, 127, 2, 0, 64, 7, 3, 5, 12, 96, 1, 30, 6};

	initial begin
		int nbeats;
		build_gauss_tab();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: count is zero out of reset, so the result is the base alone
		pending_beats.push_back(eval_beat(0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
		pending_beats.push_back(eval_beat(-1, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1, -1));
		// loads: unit radius at origin with top weights, tiny radius at the corner,
		// widest radius, a mid entry, zero radius into the last slot
		pending_beats.push_back(load_beat(0, 0, 0, 0, 32'h0001_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
		pending_beats.push_back(load_beat(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1,
			32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
		pending_beats.push_back(load_beat(2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'hFFFF_FFFF, 32'h0001_0000, -32'sh0002_0000, 32'h0000_8000));
		pending_beats.push_back(load_beat(3, 32'h0002_0000, -32'sh0001_8000, 32'h0000_4000,
			32'h0008_0000, 32'h0010_0000, -32'sh0010_0000, 32'h0003_0000));
		pending_beats.push_back(load_beat(63, -1, 1, -1, 0, -1, -1, -1));
		write_count(7'd4);
		// point on a centre, near miss, far away, with bases at the rails
		pending_beats.push_back(eval_beat(0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
		pending_beats.push_back(eval_beat(0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
		pending_beats.push_back(eval_beat(32'h0000_8000, 0, 0, 0, 0, 0));
		pending_beats.push_back(eval_beat(32'h0004_0000, 32'h0004_0000, 0, 5, -5, 7));
		pending_beats.push_back(eval_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0));
		pending_beats.push_back(eval_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1, 1));
		pending_beats.push_back(eval_beat(32'h0002_0000, -32'sh0001_8000, 32'h0000_4000, 0, 0, 0));
		pending_beats.push_back(eval_beat(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 3, 3, 3));

		// fill every slot in order with evaluates mixed in, count stays at the written prefix
		for (int s = 0; s < NUM_SLOTS; s++) begin
			pending_beats.push_back(rand_beat(1'b1, s));
			if (s % 2 == 0) pending_beats.push_back(rand_beat(1'b0, 0));
		end

		// random phases, every slot written so any count is legal
		foreach (phase_counts[ph]) begin
			write_count(7'(phase_counts[ph]));
			no_idle = (ph % 4 == 3);
			nbeats = phase_counts[ph] >= 30 ? 60 : 190;
			for (int k = 0; k < nbeats; k++)
				pending_beats.push_back(rand_beat($urandom_range(0, 3) == 0,
					$urandom_range(0, NUM_SLOTS - 1)));
		end

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d beats (%0d loads), %0d displacements checked, %0d saturated",
			beats_taken, loads_taken, disp_checked, sat_seen);
		$display("landmark counts from 0 to 127 over %0d phases", $size(phase_counts) + 2);
		if (fail_count == 0 && expected_disp.size() == 0)
			$display("gaussian_rbf_field_eval_top verification clean");
		else
			$display("gaussian_rbf_field_eval_top verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#60ms;
		$display("gaussian_rbf_field_eval_top verification failed");
		$finish;
	end

endmodule
